// File: rtl/pda_pkg.sv
// Shared widths, constants and handshake types for the path distance accumulator.
package pda_pkg;

    // Coordinate and total widths of the external fields.
    localparam int COORD_W = 24;
    localparam int TOTAL_W = 48;

    // Derived datapath widths: |dx| fits COORD_W bits, dx^2 + dy^2 fits
    // 2*COORD_W+1 bits, so the root fits COORD_W+1 bits.
    localparam int SQ_W   = 2 * COORD_W;
    localparam int ROOT_W = COORD_W + 1;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    // Coordinate selector codes.
    localparam logic FUNC_X = 1'b0;
    localparam logic FUNC_Y = 1'b1;

    // Request to the square root unit.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] radicand;
    } pda_sqrt_req_t;

    // Response of the square root unit.
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } pda_sqrt_rsp_t;

endpackage

// File: rtl/pda_coord_if.sv
// Coordinate input channel: valid/ready handshake with selector and value.
interface pda_coord_if;
    import pda_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [COORD_W-1:0] coord_value;

    modport source (output valid, output func, output coord_value, input ready);
    modport sink   (input valid, input func, input coord_value, output ready);
endinterface

// File: rtl/pda_result_if.sv
// Result output channel: valid/ready handshake with total and status flags.
interface pda_result_if;
    import pda_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_distance;
    logic               leg_added;
    logic               waiting_first;

    modport source (output valid, output total_distance, output leg_added,
                    output waiting_first, input ready);
    modport sink   (input valid, input total_distance, input leg_added,
                    input waiting_first, output ready);
endinterface

// File: rtl/path_distance_accumulator.sv
// Path distance accumulator: coordinates come in one at a time (x or y);
// each completed x/y pair after the first adds floor(sqrt(dx^2 + dy^2)) to a
// 48-bit saturating total in the coordinate's fixed-point scale. Every
// coordinate transfer yields exactly one result transfer. A coordinate that
// does not finish a leg, including the first pair, goes from idle through the
// post state into the output register. A coordinate that finishes a leg
// passes through steps for the differences, the two squares on the shared
// multiplier and the root start, then waits on the bit-serial square root
// unit (25 root bits, one per cycle, and then the completion report), then
// the accumulate and the result load. The result load waits while the
// previous result is still held in the output register. A new coordinate is
// taken when the sequencer is idle, even while the previous result still
// waits in the output register.
module path_distance_accumulator (
    input logic          clk,
    input logic          rst_n,
    pda_coord_if.sink    coord,
    pda_result_if.source result
);
    import pda_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIFF    = 3'd1;
    localparam logic [2:0] S_SQX     = 3'd2;
    localparam logic [2:0] S_SQY     = 3'd3;
    localparam logic [2:0] S_ROOT_GO = 3'd4;
    localparam logic [2:0] S_ROOT    = 3'd5;
    localparam logic [2:0] S_ACC     = 3'd6;
    localparam logic [2:0] S_POST    = 3'd7;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic signed [COORD_W-1:0] cur_x_reg;
    logic signed [COORD_W-1:0] cur_x_next;
    logic signed [COORD_W-1:0] cur_y_reg;
    logic signed [COORD_W-1:0] cur_y_next;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic signed [COORD_W-1:0] prev_y_next;
    logic                      have_x_reg;
    logic                      have_x_next;
    logic                      have_y_reg;
    logic                      have_y_next;
    logic                      first_reg;
    logic                      first_next;
    logic [TOTAL_W-1:0]        total_reg;
    logic [TOTAL_W-1:0]        total_next;
    logic                      added_reg;
    logic                      added_next;

    logic [COORD_W-1:0]        dx_reg;
    logic [COORD_W-1:0]        dx_next;
    logic [COORD_W-1:0]        dy_reg;
    logic [COORD_W-1:0]        dy_next;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W-1:0]           sq_next;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [TOTAL_W-1:0]        out_total_reg;
    logic [TOTAL_W-1:0]        out_total_next;
    logic                      out_added_reg;
    logic                      out_added_next;
    logic                      out_first_reg;
    logic                      out_first_next;

    logic                      in_xfer;
    logic                      pair_done;
    logic                      get_x;
    logic                      get_y;
    logic [COORD_W:0]          dx_signed;
    logic [COORD_W:0]          dy_signed;
    logic [COORD_W:0]          dx_abs;
    logic [COORD_W:0]          dy_abs;
    logic [COORD_W-1:0]        mul_op;
    logic [SQ_W-1:0]           mul_res;
    logic [TOTAL_W:0]          acc_sum;
    logic                      out_free;
    pda_sqrt_req_t             sqrt_req;
    pda_sqrt_rsp_t             sqrt_rsp;

    assign coord.ready = (state_reg == S_IDLE);
    assign in_xfer     = coord.valid && coord.ready;
    assign get_x       = (coord.func == FUNC_X);
    assign get_y       = (coord.func == FUNC_Y);
    assign pair_done   = (have_x_reg || get_x) && (have_y_reg || get_y);
    assign out_free    = !out_valid_reg || result.ready;

    // Signed differences, one bit wider, and their magnitudes.
    assign dx_signed = {cur_x_reg[COORD_W-1], cur_x_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign dy_signed = {cur_y_reg[COORD_W-1], cur_y_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};
    assign dx_abs    = dx_signed[COORD_W] ? -dx_signed : dx_signed;
    assign dy_abs    = dy_signed[COORD_W] ? -dy_signed : dy_signed;

    // Shared squaring multiplier: dx in one cycle, dy in the next.
    assign mul_op  = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign mul_res = {{COORD_W{1'b0}}, mul_op} * {{COORD_W{1'b0}}, mul_op};

    // Saturating accumulate; the carry out marks overflow of the total.
    assign acc_sum = {1'b0, total_reg} + {{(TOTAL_W + 1 - ROOT_W){1'b0}}, sqrt_rsp.root};

    assign sqrt_req.start    = (state_reg == S_ROOT_GO);
    assign sqrt_req.radicand = sum_reg;

    pda_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_x_next    = have_x_reg;
        have_y_next    = have_y_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        added_next     = added_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_total_next = out_total_reg;
        out_added_next = out_added_reg;
        out_first_next = out_first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    added_next = 1'b0;
                    if (get_x)
                    begin
                        cur_x_next = coord.coord_value;
                    end
                    else
                    begin
                        cur_y_next = coord.coord_value;
                    end
                    if (!pair_done)
                    begin
                        have_x_next = have_x_reg || get_x;
                        have_y_next = have_y_reg || get_y;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        have_x_next = 1'b0;
                        have_y_next = 1'b0;
                        if (first_reg)
                        begin
                            // First pair only seeds the previous position.
                            first_next  = 1'b0;
                            prev_x_next = get_x ? coord.coord_value : cur_x_reg;
                            prev_y_next = get_y ? coord.coord_value : cur_y_reg;
                            state_next  = S_POST;
                        end
                        else
                        begin
                            state_next = S_DIFF;
                        end
                    end
                end
            end
            S_DIFF:
            begin
                dx_next     = dx_abs[COORD_W-1:0];
                dy_next     = dy_abs[COORD_W-1:0];
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                state_next  = S_SQX;
            end
            S_SQX:
            begin
                sq_next    = mul_res;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = {{(SUM_W - SQ_W){1'b0}}, sq_reg} + {{(SUM_W - SQ_W){1'b0}}, mul_res};
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                total_next = acc_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : acc_sum[TOTAL_W-1:0];
                added_next = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    out_added_next = added_reg;
                    out_first_next = first_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and model state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_x_reg    <= 1'b0;
            have_y_reg    <= 1'b0;
            first_reg     <= 1'b1;
            total_reg     <= '0;
            added_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_x_reg    <= have_x_next;
            have_y_reg    <= have_y_next;
            first_reg     <= first_next;
            total_reg     <= total_next;
            added_reg     <= added_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result payload registers.
    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sq_reg        <= sq_next;
        sum_reg       <= sum_next;
        out_total_reg <= out_total_next;
        out_added_reg <= out_added_next;
        out_first_reg <= out_first_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.total_distance = out_total_reg;
    assign result.leg_added      = out_added_reg;
    assign result.waiting_first  = out_first_reg;

`ifndef SYNTH
    // A leg can only be reported once the first pair has been seen.
    a_leg_after_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_added_reg) |-> !out_first_reg)
        else $error("leg reported before the first pair");

    // The running total never decreases.
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");

    // Both fresh marks are never left set between items.
    a_no_stale_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(have_x_reg && have_y_reg))
        else $error("complete pair left pending");

    // The root unit only completes while the sequencer waits for it.
    a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> (state_reg == S_ROOT))
        else $error("root finished outside its wait state");
`endif

endmodule

// File: rtl/pda_sqrt.sv
// Iterative integer square root: one root bit per cycle, restoring method.
module pda_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pda_pkg::pda_sqrt_req_t req,
    output pda_pkg::pda_sqrt_rsp_t rsp
);
    import pda_pkg::*;

    logic [SUM_W-1:0]  op_reg;
    logic [SUM_W-1:0]  op_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_diff;

    // One step: bring down two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[REM_W-3:0], op_reg[SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;

    always_comb
    begin
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            op_next   = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[SUM_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_diff;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is loaded on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

`ifndef SYNTH
    // A new root is never requested while one is in progress.
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("sqrt started while busy");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("sqrt done held longer than one cycle");

    // The step counter stays within the root width while running.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < CNT_W'(ROOT_W)))
        else $error("sqrt step counter out of range");
`endif

endmodule
